>>> design/afp_pkg.sv
// afp_pkg: shared types, character codes, opcodes and status codes for the
// ascii frame number parser. No dependencies.
package afp_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int MAX_DIGITS_DEF   = 3;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_REARM = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_FORMAT    = 3'd2;
  localparam logic [2:0] ST_COUNT     = 3'd3;
  localparam logic [2:0] ST_NON_DIGIT = 3'd4;

  localparam logic MODE_MARKER   = 1'b0;
  localparam logic MODE_DISTANCE = 1'b1;

  // distance frames always carry three digits after the LF
  localparam int DIST_DIGITS = 3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       frame_kind;
    logic [2:0] parse_status;
    logic [9:0] parsed_value;
    logic [7:0] held_number;
    logic [9:0] held_distance;
    logic       rx_halted;
  } result_t;

  typedef struct packed {
    logic frame_mode;
  } cfg_word_t;

  typedef struct packed {
    logic fire;
    logic cfg_we;
    logic cfg_mode;
  } step_t;

endpackage

>>> design/afp_stream_if.sv
// afp_stream_if: valid/ready channel carrying one word of a chosen type.
// Used with the types of afp_pkg.
interface afp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/afp_in_stage.sv
// afp_in_stage: input register for received words.
// Depends on afp_pkg and afp_stream_if.
module afp_in_stage
  import afp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  afp_stream_if.sink   item,
  input  logic         advance,
  output logic         held_valid,
  output item_t        held_word
);

  assign item.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_word <= item.data;
    end
  end

endmodule

>>> design/afp_parse.sv
// afp_parse: frame state and the per-word update, producing a result word
// on a terminator. Depends on afp_pkg.
module afp_parse
  import afp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int MAX_DIGITS   = MAX_DIGITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  step_t   step,
  input  item_t   word,
  output logic    res_valid,
  output result_t res
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH);

  logic             frame_mode, frame_mode_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             zero_seen, zero_seen_next;
  logic [CNT_W-1:0] zero_pos, zero_pos_next;
  logic             header_ok, header_ok_next;
  logic             digits_ok, digits_ok_next;
  logic [9:0]       acc, acc_next;
  logic             halted, halted_next;
  logic [7:0]       number, number_next;
  logic [9:0]       distance, distance_next;

  logic [CNT_W-1:0] pos;
  logic [CNT_W:0]   n, len;
  logic [7:0]       b;
  logic             is_digit;
  logic [CNT_W-1:0] first_pos, last_pos;
  logic             in_window, past_window;
  logic [9:0]       acc_step;
  logic [2:0]       status;
  logic [9:0]       value;

  assign pos       = byte_count;
  assign b         = word.rx_byte;
  assign n         = {1'b0, pos} + (CNT_W + 1)'(1);
  assign len       = zero_seen ? {1'b0, zero_pos} : n;
  assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign first_pos = (frame_mode == MODE_DISTANCE) ? CNT_W'(1) : CNT_W'(2);
  assign last_pos  = (frame_mode == MODE_DISTANCE) ? CNT_W'(1 + DIST_DIGITS)
                                                   : CNT_W'(2 + MAX_DIGITS);
  assign in_window   = (pos >= first_pos) && (pos < last_pos);
  assign past_window = (pos >= last_pos);
  assign acc_step  = {acc[6:0], 3'b000} + {acc[8:0], 1'b0} + {6'd0, b[3:0] - CH_ZERO[3:0]};

  always_comb begin
    frame_mode_next = frame_mode;
    byte_count_next = byte_count;
    zero_seen_next  = zero_seen;
    zero_pos_next   = zero_pos;
    header_ok_next  = header_ok;
    digits_ok_next  = digits_ok;
    acc_next        = acc;
    halted_next     = halted;
    number_next     = number;
    distance_next   = distance;
    res_valid       = 1'b0;
    status          = ST_OK;
    value           = 10'd0;

    if (step.cfg_we) begin
      frame_mode_next = step.cfg_mode;
      byte_count_next = '0;
      zero_seen_next  = 1'b0;
      zero_pos_next   = '0;
      header_ok_next  = 1'b0;
      digits_ok_next  = 1'b1;
      acc_next        = 10'd0;
    end else if (step.fire) begin
      unique case (word.opcode)
        OP_REARM: halted_next = 1'b0;
        OP_CLEAR: number_next = 8'd0;
        OP_BYTE: begin
          if (!halted) begin
            if (byte_count >= CNT_W'(BUFFER_DEPTH - 1)) begin
              byte_count_next = '0;
              zero_seen_next  = 1'b0;
              zero_pos_next   = '0;
              header_ok_next  = 1'b0;
              digits_ok_next  = 1'b1;
              acc_next        = 10'd0;
            end else if (frame_mode == MODE_DISTANCE && pos == '0 && b != CH_LF) begin
              byte_count_next = byte_count;
            end else begin
              byte_count_next = n[CNT_W-1:0];
              if (frame_mode == MODE_MARKER) begin
                if (pos == CNT_W'(0)) begin
                  header_ok_next = (b == CH_HASH);
                end else if (pos == CNT_W'(1)) begin
                  header_ok_next = header_ok && (b == CH_LOW_A);
                end
              end
              if ((frame_mode == MODE_MARKER && b != CH_BANG) ||
                  (frame_mode == MODE_DISTANCE && b != CH_CR)) begin
                // ordinary frame byte
                if (b == CH_NUL && !zero_seen) begin
                  zero_seen_next = 1'b1;
                  zero_pos_next  = pos;
                end
                if (in_window) begin
                  if (is_digit) begin
                    acc_next = acc_step;
                  end else begin
                    digits_ok_next = 1'b0;
                  end
                end else if (past_window && !is_digit) begin
                  digits_ok_next = 1'b0;
                end
              end else begin
                // terminator
                res_valid = 1'b1;
                if (frame_mode == MODE_MARKER) begin
                  if (len < (CNT_W + 1)'(4)) begin
                    status = ST_SHORT;
                  end else if (!header_ok_next || zero_seen) begin
                    status = ST_FORMAT;
                  end else if (pos == CNT_W'(2) || pos > CNT_W'(2 + MAX_DIGITS)) begin
                    status = ST_COUNT;
                  end else if (!digits_ok) begin
                    status = ST_NON_DIGIT;
                  end else begin
                    value = {2'b00, acc[7:0]};
                  end
                  number_next = value[7:0];
                  if (value != 10'd0) begin
                    halted_next = 1'b1;
                  end
                end else begin
                  if (len < (CNT_W + 1)'(5)) begin
                    status = ST_SHORT;
                  end else if (zero_seen) begin
                    status = ST_FORMAT;
                  end else if (n != (CNT_W + 1)'(5)) begin
                    status = ST_COUNT;
                  end else if (!digits_ok) begin
                    status = ST_NON_DIGIT;
                  end else begin
                    value         = acc;
                    distance_next = acc;
                  end
                end
                byte_count_next = '0;
                zero_seen_next  = 1'b0;
                zero_pos_next   = '0;
                header_ok_next  = 1'b0;
                digits_ok_next  = 1'b1;
                acc_next        = 10'd0;
              end
            end
          end
        end
        default: begin
          byte_count_next = byte_count;
        end
      endcase
    end
  end

  assign res.frame_kind    = frame_mode;
  assign res.parse_status  = status;
  assign res.parsed_value  = value;
  assign res.held_number   = number_next;
  assign res.held_distance = distance_next;
  assign res.rx_halted     = halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= MODE_MARKER;
      byte_count <= '0;
      zero_seen  <= 1'b0;
      zero_pos   <= '0;
      header_ok  <= 1'b0;
      digits_ok  <= 1'b1;
      acc        <= 10'd0;
      halted     <= 1'b0;
      number     <= 8'd0;
      distance   <= 10'd0;
    end else begin
      frame_mode <= frame_mode_next;
      byte_count <= byte_count_next;
      zero_seen  <= zero_seen_next;
      zero_pos   <= zero_pos_next;
      header_ok  <= header_ok_next;
      digits_ok  <= digits_ok_next;
      acc        <= acc_next;
      halted     <= halted_next;
      number     <= number_next;
      distance   <= distance_next;
    end
  end

endmodule

>>> design/afp_out_stage.sv
// afp_out_stage: result register on the output channel.
// Depends on afp_pkg and afp_stream_if.
module afp_out_stage
  import afp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_t      res,
  output logic         take,
  afp_stream_if.source result
);

  // room for a new word when empty or being emptied this cycle
  assign take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.data <= res;
    end
  end

endmodule

>>> design/ascii_frame_number_parser_core.sv
// ascii_frame_number_parser_core: top level of the frame parser.
// Depends on afp_pkg, afp_stream_if, afp_in_stage, afp_parse, afp_out_stage.
//
// Takes one word per cycle on item (opcode and received byte) while result
// is not stalled, and gives one result word on result for each frame
// terminator taken while not halted: '!' in marker mode, CR in distance mode.
// A word passes an input register, then the frame state update writes the
// result register. The mode register is written on cfg, always ready; it is
// to be written only while no word is in flight, which the block itself does
// not enforce. A write discards the frame in progress.
module ascii_frame_number_parser_core
  import afp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int MAX_DIGITS   = MAX_DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  afp_stream_if.sink   cfg,
  afp_stream_if.sink   item,
  afp_stream_if.source result
);

  logic    held_valid;
  item_t   held_word;
  logic    take;
  logic    advance;
  step_t   step;
  logic    res_valid;
  result_t res;

  assign cfg.ready = 1'b1;
  assign advance   = held_valid && take;

  assign step.fire     = advance;
  assign step.cfg_we   = cfg.valid && cfg.ready;
  assign step.cfg_mode = cfg.data.frame_mode;

  afp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  afp_parse #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_DIGITS   (MAX_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word      (held_word),
    .res_valid (res_valid),
    .res       (res)
  );

  afp_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && res_valid),
    .res    (res),
    .take   (take),
    .result (result)
  );

endmodule

>>> design/afp_checker.sv
// afp_checker: port-level checks on the frame parser results, bound to the
// top level. Depends on afp_pkg.
module afp_checker
  import afp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.parse_status != ST_OK |-> out_word.parsed_value == 10'd0)
    else $error("nonzero value on a failed frame");

  a_marker_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.frame_kind == MODE_MARKER |->
      out_word.held_number == out_word.parsed_value[7:0] &&
      (out_word.parsed_value == 10'd0 || out_word.rx_halted))
    else $error("marker result does not match held number or halt");

  a_dist_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.frame_kind == MODE_DISTANCE &&
      out_word.parse_status == ST_OK |-> out_word.held_distance == out_word.parsed_value)
    else $error("good distance not held");

endmodule

bind ascii_frame_number_parser_core afp_checker u_afp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_word  (result.data)
);

>>> bench/tb.sv
// tb: self-checking bench for ascii_frame_number_parser_core, marker and distance modes.
// Depends on afp_pkg, afp_stream_if and the parser core in design/.
`timescale 1ns / 100ps

module tb
  import afp_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 95;

  // running frame state and expected results, word by word
  class frame_tracker;
    logic        mode;
    int unsigned stored;
    bit          nul_seen;
    int unsigned nul_pos;
    bit          header_good;
    bit          digits_good;
    logic [9:0]  acc;
    bit          halted;
    logic [7:0]  number;
    logic [9:0]  distance;
    result_t     due_results[$];
    int          mismatches;

    function new();
      mode = MODE_MARKER;
      halted = 0;
      number = '0;
      distance = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      stored = 0;
      nul_seen = 0;
      nul_pos = 0;
      header_good = 0;
      digits_good = 1;
      acc = '0;
    endfunction

    function void apply_mode(logic m);
      mode = m;
      restart();
    endfunction

    function int pending_count();
      return due_results.size();
    endfunction

    function void take_char(int unsigned pos, logic [7:0] b, int unsigned first,
                            int unsigned ndig);
      bit is_digit;
      int sum;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      if (b == CH_NUL && !nul_seen) begin
        nul_seen = 1;
        nul_pos = pos;
      end
      if (pos >= first && pos < first + ndig) begin
        if (is_digit) begin
          sum = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
          acc = sum[9:0];
        end else begin
          digits_good = 0;
        end
      end else if (pos >= first + ndig && !is_digit) begin
        digits_good = 0;
      end
    endfunction

    function void take_word(item_t it);
      int unsigned pos;
      int unsigned n;
      int unsigned len;
      logic [2:0]  st;
      logic [9:0]  val;
      result_t     r;
      st = ST_OK;
      val = '0;
      if (it.opcode == OP_REARM) begin
        halted = 0;
        return;
      end
      if (it.opcode == OP_CLEAR) begin
        number = '0;
        return;
      end
      if (it.opcode != OP_BYTE || halted) return;
      if (stored >= BUFFER_DEPTH_DEF - 1) begin
        restart();
        return;
      end
      pos = stored;
      if (mode == MODE_MARKER) begin
        if (pos == 0) header_good = (it.rx_byte == CH_HASH);
        else if (pos == 1) header_good = header_good && (it.rx_byte == CH_LOW_A);
        stored = pos + 1;
        if (it.rx_byte != CH_BANG) begin
          take_char(pos, it.rx_byte, 2, MAX_DIGITS_DEF);
          return;
        end
        n = pos + 1;
        len = nul_seen ? nul_pos : n;
        if (len < 4) st = ST_SHORT;
        else if (!header_good || nul_seen) st = ST_FORMAT;
        else if (pos - 2 == 0 || pos - 2 > MAX_DIGITS_DEF) st = ST_COUNT;
        else if (!digits_good) st = ST_NON_DIGIT;
        else val = {2'b00, acc[7:0]};
        number = val[7:0];
        if (val != 0) halted = 1;
      end else begin
        if (pos == 0 && it.rx_byte != CH_LF) return;
        stored = pos + 1;
        if (it.rx_byte != CH_CR) begin
          take_char(pos, it.rx_byte, 1, DIST_DIGITS);
          return;
        end
        n = pos + 1;
        len = nul_seen ? nul_pos : n;
        if (len < 5) st = ST_SHORT;
        else if (nul_seen) st = ST_FORMAT;
        else if (n != 5) st = ST_COUNT;
        else if (!digits_good) st = ST_NON_DIGIT;
        else begin
          val = acc;
          distance = val;
        end
      end
      r.frame_kind = mode;
      r.parse_status = st;
      r.parsed_value = val;
      r.held_number = number;
      r.held_distance = distance;
      r.rx_halted = halted;
      due_results.push_back(r);
      restart();
    endfunction

    function void cmp(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      cmp("frame_kind", want.frame_kind, got.frame_kind);
      cmp("parse_status", want.parse_status, got.parse_status);
      cmp("parsed_value", want.parsed_value, got.parsed_value);
      cmp("held_number", want.held_number, got.held_number);
      cmp("held_distance", want.held_distance, got.held_distance);
      cmp("rx_halted", want.rx_halted, got.rx_halted);
    endfunction

    function void check_drained();
      if (due_results.size() != 0) begin
        $display("%0t: results missing, expected %0d more, actual 0", $time,
                 due_results.size());
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  afp_stream_if #(.T(cfg_word_t)) cfg_if ();
  afp_stream_if #(.T(item_t))     item_if ();
  afp_stream_if #(.T(result_t))   res_if ();

  ascii_frame_number_parser_core dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .item(item_if),
    .result(res_if)
  );

  frame_tracker tracker = new();

  item_t frame_q[$];
  int    send_idle = 0;
  int    recv_idle = 0;
  bit    stall_go = 0;
  bit    stall_taken = 0;
  int    hold_left = 0;
  int    cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_go && !stall_taken) begin
      res_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      stall_taken <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) tracker.compare_result(res_if.data);
      if (cfg_if.valid && cfg_if.ready) tracker.apply_mode(cfg_if.data.frame_mode);
      if (item_if.valid && item_if.ready) tracker.take_word(item_if.data);
    end
  end

  function automatic void push(logic [1:0] op, logic [7:0] b);
    item_t it;
    it.opcode = op;
    it.rx_byte = b;
    frame_q.push_back(it);
  endfunction

  task automatic send_word(item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data <= it;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
  endtask

  task automatic send_frame_q(inout int sent);
    foreach (frame_q[i]) send_word(frame_q[i]);
    sent += frame_q.size();
    frame_q.delete();
  endtask

  task automatic program_mode(logic m);
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data.frame_mode <= m;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic build_frame(logic m);
    int         r;
    int         nd;
    int         idx;
    logic [7:0] term;
    logic [7:0] b;
    term = m ? CH_CR : CH_BANG;
    r = $urandom_range(99);
    if (r < 15) begin
      // noise, all opcodes
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(99) < 70) push(OP_BYTE, 8'($urandom_range(255)));
        else push(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end else if (r < 18) begin
      // run up against the full buffer
      if (m) push(OP_BYTE, CH_LF);
      repeat ($urandom_range(61, 65)) begin
        b = 8'($urandom_range(255));
        if (b == term) b = CH_ZERO;
        push(OP_BYTE, b);
      end
      push(OP_BYTE, term);
      push(OP_REARM, 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 85) nd = m ? DIST_DIGITS : $urandom_range(1, MAX_DIGITS_DEF);
      else nd = $urandom_range(0, 5);
      if (m) begin
        push(OP_BYTE, CH_LF);
      end else begin
        push(OP_BYTE, CH_HASH);
        push(OP_BYTE, CH_LOW_A);
      end
      repeat (nd) push(OP_BYTE, CH_ZERO + 8'($urandom_range(9)));
      if (r < 92) push(OP_BYTE, term);
      if ($urandom_range(99) < 20) begin
        idx = $urandom_range(frame_q.size() - 1);
        case ($urandom_range(4))
          0: frame_q[idx].rx_byte = CH_NUL;
          1: frame_q[idx].rx_byte = 8'hFF;
          2: frame_q[idx].rx_byte = term;
          3: frame_q[idx].rx_byte = CH_ZERO + 8'($urandom_range(9));
          default: frame_q[idx].rx_byte = 8'($urandom_range(255));
        endcase
      end
      if ($urandom_range(99) < (m ? 10 : 85)) push(OP_REARM, 8'($urandom_range(255)));
      if ($urandom_range(99) < 10) push(OP_CLEAR, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int sent;
    int k;
    logic m;
    item_if.valid <= 1'b0;
    item_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: halt and rearm, clear, unused opcode, zero value, short frames
    sent = 0;
    push(OP_BYTE, CH_HASH);
    push(OP_BYTE, CH_LOW_A);
    push(OP_BYTE, CH_ZERO + 8'd2);
    push(OP_BYTE, CH_ZERO + 8'd5);
    push(OP_BYTE, CH_ZERO + 8'd5);
    push(OP_BYTE, CH_BANG);
    push(OP_BYTE, CH_HASH);
    push(OP_REARM, 8'h00);
    push(OP_CLEAR, 8'hFF);
    push(OP_SPARE, 8'h00);
    push(OP_BYTE, CH_HASH);
    push(OP_BYTE, CH_LOW_A);
    push(OP_BYTE, CH_ZERO);
    push(OP_BYTE, CH_BANG);
    push(OP_BYTE, CH_BANG);
    send_frame_q(sent);
    program_mode(MODE_DISTANCE);
    push(OP_BYTE, CH_LF);
    push(OP_BYTE, CH_NINE);
    push(OP_BYTE, CH_NINE);
    push(OP_BYTE, CH_NINE);
    push(OP_BYTE, CH_CR);
    push(OP_BYTE, CH_LF);
    push(OP_BYTE, CH_ZERO);
    push(OP_BYTE, CH_CR);
    send_frame_q(sent);

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 10 : (p == 1) ? 78 : 0;
      recv_idle <= (p == 0) ? 78 : (p == 1) ? 10 : 0;
      if (p == 2) stall_go <= 1'b1;
      for (int s = 0; s < 2; s++) begin
        m = s[0] ^ p[0];
        program_mode(m);
        push(OP_REARM, 8'($urandom_range(255)));
        sent = 0;
        while (sent < PHASE_WORDS) begin
          build_frame(m);
          send_frame_q(sent);
        end
      end
    end

    item_if.valid <= 1'b0;
    @(posedge clk);
    k = 0;
    while (tracker.pending_count() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
    tracker.check_drained();
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
